// ----- sv/hdbn_pkg.sv -----
// ----------------------------------------------------------------------------
// hdbn_pkg
// Shared types and codes for the HDBn line encoder.
// ----------------------------------------------------------------------------
package hdbn_pkg;

  // Ternary line symbol, two's complement.
  typedef logic signed [1:0] sym_t;

  localparam sym_t SYM_ZERO = 2'sb00;
  localparam sym_t SYM_POS  = 2'sb01;
  localparam sym_t SYM_NEG  = 2'sb11;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_RUN_LENGTH                 = 2'd0;
  localparam cfg_index_t REG_INITIAL_PULSE_POSITIVE     = 2'd1;
  localparam cfg_index_t REG_INITIAL_VIOLATION_POSITIVE = 2'd2;

  localparam cfg_data_t RUN_LENGTH_RESET = 4'd4;
  localparam int        RUN_LENGTH_MIN   = 2;

  // Shape of the symbols released by one item: the first symbol (balancing
  // pulse slot), the last symbol, everything in between is zero.
  typedef struct packed {
    sym_t first_sym;
    sym_t last_sym;
    logic done;
  } burst_t;

  // One queued output symbol.
  typedef struct packed {
    sym_t symbol;
    logic last_of_burst;
    logic message_done;
  } slot_t;

endpackage

// ----- sv/hdbn_if.sv -----
// ----------------------------------------------------------------------------
// hdbn_if
// Valid/ready channels of the HDBn line encoder: message bits in, symbols out.
// ----------------------------------------------------------------------------
interface hdbn_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic first_of_message;
  logic end_of_message;

  modport source (output valid, output data_bit, output first_of_message,
                  output end_of_message, input ready);
  modport sink (input valid, input data_bit, input first_of_message,
                input end_of_message, output ready);
endinterface

interface hdbn_out_if;
  logic             valid;
  logic             ready;
  hdbn_pkg::sym_t   symbol;
  logic             last_of_burst;
  logic             message_done;

  modport source (output valid, output symbol, output last_of_burst,
                  output message_done, input ready);
  modport sink (input valid, input symbol, input last_of_burst,
                input message_done, output ready);
endinterface

// ----- sv/hdbn_enc.sv -----
// ----------------------------------------------------------------------------
// hdbn_enc
// Configuration registers and encoder state; turns each item into a burst
// descriptor (length and shape of the symbols it releases).
// ----------------------------------------------------------------------------
module hdbn_enc #(
  parameter int MAX_RUN = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  hdbn_pkg::cfg_index_t                cfg_index,
  input  hdbn_pkg::cfg_data_t                 cfg_data,
  input  logic                                accept,
  input  logic                                data_bit,
  input  logic                                first_of_message,
  input  logic                                end_of_message,
  output logic [$clog2(MAX_RUN+1)-1:0]        len,
  output hdbn_pkg::burst_t                    burst
);
  import hdbn_pkg::*;

  localparam int LW = $clog2(MAX_RUN + 1);
  localparam int HW = $clog2(MAX_RUN);

  function automatic logic [LW-1:0] run_clip(input cfg_data_t v);
    int r;
    r = int'(v);
    if (r < RUN_LENGTH_MIN) r = RUN_LENGTH_MIN;
    if (r > MAX_RUN) r = MAX_RUN;
    return LW'(r);
  endfunction

  logic [LW-1:0] run_eff;
  logic          init_pulse_pos;
  logic          init_viol_pos;

  logic [HW-1:0] held_zero_count, held_zero_count_next;
  logic          last_pulse_positive, last_pulse_positive_next;
  logic          last_violation_positive, last_violation_positive_next;

  logic [HW-1:0] held_eff;
  logic          lp, lv, v_pos;
  logic [LW-1:0] cnt;
  sym_t          v_sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_eff        <= run_clip(RUN_LENGTH_RESET);
      init_pulse_pos <= 1'b0;
      init_viol_pos  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_LENGTH:                 run_eff        <= run_clip(cfg_data);
        REG_INITIAL_PULSE_POSITIVE:     init_pulse_pos <= cfg_data[0];
        REG_INITIAL_VIOLATION_POSITIVE: init_viol_pos  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Start of message reloads polarities and drops any held run.
  always_comb begin
    held_eff = first_of_message ? '0 : held_zero_count;
    lp       = first_of_message ? init_pulse_pos : last_pulse_positive;
    lv       = first_of_message ? init_viol_pos : last_violation_positive;
    cnt      = LW'(held_eff) + LW'(1);
    v_pos    = !lv;
    v_sym    = v_pos ? SYM_POS : SYM_NEG;
  end

  always_comb begin
    len                          = '0;
    burst.first_sym              = SYM_ZERO;
    burst.last_sym               = SYM_ZERO;
    burst.done                   = end_of_message;
    held_zero_count_next         = '0;
    last_pulse_positive_next     = lp;
    last_violation_positive_next = lv;
    if (data_bit) begin
      // held zeros, then a pulse of alternated polarity
      len                      = cnt;
      burst.last_sym           = lp ? SYM_NEG : SYM_POS;
      last_pulse_positive_next = !lp;
    end else if (cnt >= run_eff) begin
      // substitution block: B (if needed) 0 .. 0 V
      len                          = run_eff;
      burst.first_sym              = (lp != v_pos) ? v_sym : SYM_ZERO;
      burst.last_sym               = v_sym;
      last_pulse_positive_next     = v_pos;
      last_violation_positive_next = v_pos;
    end else if (end_of_message) begin
      len = cnt;
    end else begin
      held_zero_count_next = HW'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_zero_count         <= '0;
      last_pulse_positive     <= 1'b0;
      last_violation_positive <= 1'b0;
    end else if (accept) begin
      held_zero_count         <= held_zero_count_next;
      last_pulse_positive     <= last_pulse_positive_next;
      last_violation_positive <= last_violation_positive_next;
    end
  end

endmodule

// ----- sv/hdbn_cell.sv -----
// ----------------------------------------------------------------------------
// hdbn_cell
// One slot of the output chain. Shifts toward the head on each pop and picks
// up its symbol from a burst when its position falls inside the burst.
// ----------------------------------------------------------------------------
module hdbn_cell #(
  parameter int POSITION = 0,
  parameter int PW       = 5,
  parameter int LW       = 4
) (
  input  logic             clk,
  input  logic             pop,
  input  logic             load,
  input  logic [PW-1:0]    base,
  input  logic [LW-1:0]    len,
  input  hdbn_pkg::burst_t burst,
  input  hdbn_pkg::slot_t  upstream,
  output hdbn_pkg::slot_t  slot
);
  import hdbn_pkg::*;

  localparam logic [PW:0] POS = (PW + 1)'(POSITION);

  logic [PW:0] first_pos, end_pos, last_pos;
  logic        hit;
  slot_t       fresh;

  always_comb begin
    first_pos = {1'b0, base};
    end_pos   = first_pos + (PW + 1)'(len);
    last_pos  = end_pos - (PW + 1)'(1);
    hit       = load && (POS >= first_pos) && (POS < end_pos);

    fresh.symbol        = SYM_ZERO;
    fresh.last_of_burst = 1'b0;
    fresh.message_done  = 1'b0;
    if (POS == last_pos) begin
      fresh.symbol        = burst.last_sym;
      fresh.last_of_burst = 1'b1;
      fresh.message_done  = burst.done;
    end else if (POS == first_pos) begin
      fresh.symbol = burst.first_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      slot <= fresh;
    end else if (pop) begin
      slot <= upstream;
    end
  end

endmodule

// ----- sv/hdbn_line_encoder.sv -----
// ----------------------------------------------------------------------------
// hdbn_line_encoder
// HDBn line encoder: one message bit per input item, ternary symbols out.
// ----------------------------------------------------------------------------
// Takes one bit per clock while ready. An item releases 0 to MAX_RUN symbols
// at once into a chain of 2*MAX_RUN symbol cells; the head cell drives the
// output and the chain shifts by one per symbol taken, so symbols leave at
// one per cycle while the sink is ready, at the earliest the cycle after the
// releasing item. Bits are accepted while at least MAX_RUN cells are free,
// which with an always-ready sink holds for any bit pattern: sustained rate
// is one item per cycle, set by the encoder state update and the chain head.
// ----------------------------------------------------------------------------
module hdbn_line_encoder #(
  parameter int MAX_RUN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  hdbn_pkg::cfg_index_t cfg_index,
  input  hdbn_pkg::cfg_data_t  cfg_data,
  hdbn_in_if.sink              bits,
  hdbn_out_if.source           symbols
);
  import hdbn_pkg::*;

  localparam int DEPTH = 2 * MAX_RUN;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int LW    = $clog2(MAX_RUN + 1);

  logic [PW-1:0] occ, occ_next, base;
  logic          accept, pop;
  logic [LW-1:0] len;
  burst_t        burst;
  slot_t         slots [DEPTH+1];

  assign bits.ready = !rst && (occ <= PW'(MAX_RUN));
  assign accept     = bits.valid && bits.ready;
  assign pop        = symbols.valid && symbols.ready;

  hdbn_enc #(
    .MAX_RUN (MAX_RUN)
  ) u_enc (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (accept),
    .data_bit         (bits.data_bit),
    .first_of_message (bits.first_of_message),
    .end_of_message   (bits.end_of_message),
    .len              (len),
    .burst            (burst)
  );

  // occupancy after this cycle's pop is where a new burst lands
  always_comb begin
    base     = occ - PW'(pop);
    occ_next = base + (accept ? PW'(len) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  assign slots[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hdbn_cell #(
      .POSITION (i),
      .PW       (PW),
      .LW       (LW)
    ) u_cell (
      .clk      (clk),
      .pop      (pop),
      .load     (accept),
      .base     (base),
      .len      (len),
      .burst    (burst),
      .upstream (slots[i+1]),
      .slot     (slots[i])
    );
  end

  assign symbols.valid         = (occ != '0);
  assign symbols.symbol        = slots[0].symbol;
  assign symbols.last_of_burst = slots[0].last_of_burst;
  assign symbols.message_done  = slots[0].message_done;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= PW'(DEPTH))
    else $error("output chain overfilled");

  a_burst_visible: assert property (@(posedge clk) disable iff (rst)
    (accept && len != '0) |=> symbols.valid)
    else $error("released burst not presented");

  a_sym_legal: assert property (@(posedge clk) disable iff (rst)
    symbols.valid |-> (symbols.symbol != 2'sb10))
    else $error("illegal symbol code at head");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (symbols.valid && symbols.message_done) |-> symbols.last_of_burst)
    else $error("message end not on last symbol of burst");
`endif

endmodule
